// ----- hw/rtl/i2c_rts_pkg.sv -----
// shared types, codes and helpers for the i2c register transfer sequencer
package i2c_rts_pkg;

  // request codes
  localparam logic [1:0] REQ_BEGIN_WRITE = 2'd0;
  localparam logic [1:0] REQ_BEGIN_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE_BYTE  = 2'd2;
  localparam logic [1:0] REQ_STATUS      = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_CMD  = 3'd0;
  localparam logic [2:0] KIND_RD   = 3'd1;
  localparam logic [2:0] KIND_OK   = 3'd2;
  localparam logic [2:0] KIND_ERR  = 3'd3;
  localparam logic [2:0] KIND_NEXT = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CTRL   = 2'd1;
  localparam logic [1:0] ERR_ZERO   = 2'd2;
  localparam logic [1:0] ERR_ACTIVE = 2'd3;

  // controller command words: bit0 run, bit1 start, bit2 stop, bit3 ack
  localparam logic [3:0] CMD_START_RUN      = 4'h3;
  localparam logic [3:0] CMD_RUN            = 4'h1;
  localparam logic [3:0] CMD_RUN_STOP       = 4'h5;
  localparam logic [3:0] CMD_START_RUN_STOP = 4'h7;
  localparam logic [3:0] CMD_START_RUN_ACK  = 4'hB;
  localparam logic [3:0] CMD_RUN_ACK        = 4'h9;

  // result queue size
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0] req;
    logic [6:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] tx_data;
    logic       ctrl_busy;
    logic       bus_busy;
    logic [2:0] error_bits;
    logic [7:0] rx_data;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] addr;
    logic [7:0] data;
    logic [3:0] ctrl;
    logic [1:0] err;
    logic       last;
  } result_t;

  // up to two results per transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic result_t make_result(logic [2:0] kind, logic [7:0] addr,
                                          logic [7:0] data, logic [3:0] ctrl,
                                          logic [1:0] err);
    result_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.ctrl = ctrl;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/i2c_rts_core.sv -----
// transfer state and per-transaction decision logic
module i2c_rts_core import i2c_rts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  output step_t step
);

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_W_ADDR   = 8'b0000_0010,
    PH_W_NEED   = 8'b0000_0100,
    PH_W_DATA   = 8'b0000_1000,
    PH_R_ADDR   = 8'b0001_0000,
    PH_R_DATA   = 8'b0010_0000,
    PH_HOLD_OK  = 8'b0100_0000,
    PH_HOLD_ERR = 8'b1000_0000
  } phase_t;

  phase_t     phase, phase_next;
  logic       is_read, is_read_next;
  logic [6:0] target_addr, target_addr_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] total_bytes, total_bytes_next;

  // decide results and next state for the current transaction
  always_comb begin
    logic       err_any;
    logic       fin_req;
    logic       fin_ok;
    logic [7:0] left_dec;
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
    result_t    fin_item;

    err_any          = (item.error_bits != 3'd0);
    fin_req          = 1'b0;
    fin_ok           = 1'b0;
    left_dec         = bytes_left - 8'd1;
    cnt              = 2'd0;
    r0               = '0;
    r1               = '0;
    phase_next       = phase;
    is_read_next     = is_read;
    target_addr_next = target_addr;
    bytes_left_next  = bytes_left;
    total_bytes_next = total_bytes;

    priority if (item.req == REQ_BEGIN_WRITE || item.req == REQ_BEGIN_READ) begin
      if (phase != PH_IDLE) begin
        r0  = make_result(KIND_ERR, 8'd0, 8'd0, 4'd0, ERR_ACTIVE);
        cnt = 2'd1;
      end else if (item.byte_count == 8'd0) begin
        r0  = make_result(KIND_ERR, 8'd0, 8'd0, 4'd0, ERR_ZERO);
        cnt = 2'd1;
      end else begin
        target_addr_next = item.slave_addr;
        is_read_next     = 1'b0;
        total_bytes_next = item.byte_count;
        bytes_left_next  = item.byte_count;
        phase_next       = (item.req == REQ_BEGIN_WRITE) ? PH_W_ADDR : PH_R_ADDR;
        r0  = make_result(KIND_CMD, {item.slave_addr, 1'b0}, item.reg_addr,
                          CMD_START_RUN, ERR_NONE);
        cnt = 2'd1;
      end
    end else if (item.req == REQ_WRITE_BYTE) begin
      if (phase == PH_W_NEED && bytes_left != 8'd0) begin
        bytes_left_next = left_dec;
        phase_next      = PH_W_DATA;
        r0  = make_result(KIND_CMD, {target_addr, is_read}, item.tx_data,
                          (left_dec == 8'd0) ? CMD_RUN_STOP : CMD_RUN, ERR_NONE);
        cnt = 2'd1;
      end
    end else if (!item.ctrl_busy) begin
      // status report from the controller
      unique case (phase)
        PH_W_ADDR, PH_R_ADDR: begin
          if (err_any) begin
            phase_next = PH_IDLE;
            r0  = make_result(KIND_ERR, 8'd0, 8'd0, 4'd0, ERR_CTRL);
            cnt = 2'd1;
          end else if (phase == PH_W_ADDR) begin
            phase_next = PH_W_NEED;
            r0  = make_result(KIND_NEXT, 8'd0, 8'd0, 4'd0, ERR_NONE);
            cnt = 2'd1;
          end else begin
            is_read_next = 1'b1;
            phase_next   = PH_R_DATA;
            r0  = make_result(KIND_CMD, {target_addr, 1'b1}, 8'd0,
                              (total_bytes == 8'd1) ? CMD_START_RUN_STOP
                                                    : CMD_START_RUN_ACK,
                              ERR_NONE);
            cnt = 2'd1;
          end
        end
        PH_W_DATA: begin
          if (bytes_left == 8'd0) begin
            fin_req = 1'b1;
            fin_ok  = !err_any;
          end else if (err_any) begin
            phase_next = PH_IDLE;
            r0  = make_result(KIND_ERR, 8'd0, 8'd0, 4'd0, ERR_CTRL);
            cnt = 2'd1;
          end else begin
            phase_next = PH_W_NEED;
            r0  = make_result(KIND_NEXT, 8'd0, 8'd0, 4'd0, ERR_NONE);
            cnt = 2'd1;
          end
        end
        PH_R_DATA: begin
          if (err_any) begin
            if (bytes_left <= 8'd1) begin
              fin_req = 1'b1;
              fin_ok  = 1'b0;
            end else begin
              phase_next = PH_IDLE;
              r0  = make_result(KIND_ERR, 8'd0, 8'd0, 4'd0, ERR_CTRL);
              cnt = 2'd1;
            end
          end else begin
            // hand back the byte, then continue or finish
            r0  = make_result(KIND_RD, 8'd0, item.rx_data, 4'd0, ERR_NONE);
            cnt = 2'd1;
            if (bytes_left <= 8'd1) begin
              bytes_left_next = 8'd0;
              fin_req         = 1'b1;
              fin_ok          = 1'b1;
            end else begin
              bytes_left_next = left_dec;
              r1  = make_result(KIND_CMD, {target_addr, is_read}, 8'd0,
                                (left_dec == 8'd1) ? CMD_RUN_STOP : CMD_RUN_ACK,
                                ERR_NONE);
              cnt = 2'd2;
            end
          end
        end
        PH_HOLD_OK, PH_HOLD_ERR: begin
          if (!item.bus_busy) begin
            fin_req = 1'b1;
            fin_ok  = (phase == PH_HOLD_OK);
          end
        end
        PH_IDLE, PH_W_NEED: begin
        end
        default: phase_next = PH_IDLE;
      endcase
    end else begin
      // busy controller: the report is ignored
    end

    // final report: held until the bus is idle
    fin_item = fin_ok ? make_result(KIND_OK, 8'd0, 8'd0, 4'd0, ERR_NONE)
                      : make_result(KIND_ERR, 8'd0, 8'd0, 4'd0, ERR_CTRL);
    if (fin_req) begin
      if (item.bus_busy) begin
        phase_next = fin_ok ? PH_HOLD_OK : PH_HOLD_ERR;
      end else begin
        phase_next = PH_IDLE;
        if (cnt == 2'd0) begin
          r0  = fin_item;
          cnt = 2'd1;
        end else begin
          r1  = fin_item;
          cnt = 2'd2;
        end
      end
    end

    // mark the final result of the transaction
    if (cnt == 2'd1) r0.last = 1'b1;
    if (cnt == 2'd2) r1.last = 1'b1;

    step.count = cnt;
    step.r0    = r0;
    step.r1    = r1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      is_read     <= 1'b0;
      target_addr <= 7'd0;
      bytes_left  <= 8'd0;
      total_bytes <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      is_read     <= is_read_next;
      target_addr <= target_addr_next;
      bytes_left  <= bytes_left_next;
      total_bytes <= total_bytes_next;
    end
  end

endmodule

// ----- hw/rtl/i2c_rts_fifo.sv -----
// small result queue taking up to two entries and giving one per cycle while rd_ready is high
module i2c_rts_fifo import i2c_rts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_count,
  input  result_t    wr0,
  input  result_t    wr1,
  output logic       room,
  output logic       rd_valid,
  input  logic       rd_ready,
  output result_t    rd_data
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               rd_take;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign rd_take  = rd_valid && rd_ready;
  assign room     = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) mem[wr_ptr] <= wr0;
    if (wr_count == 2'd2) mem[FIFO_AW'(wr_ptr + 1'b1)] <= wr1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_AW'(wr_ptr + FIFO_AW'(wr_count));
      if (rd_take) rd_ptr <= FIFO_AW'(rd_ptr + 1'b1);
      count  <= (FIFO_AW + 1)'(count + (FIFO_AW + 1)'(wr_count)
                - (FIFO_AW + 1)'(rd_take));
    end
  end

endmodule

// ----- hw/rtl/i2c_register_transfer_sequencer.sv -----
// top level of the i2c register transfer sequencer
//
// Input channel (in_valid/in_ready) carries begin-write, begin-read,
// next-write-byte requests and controller status reports. The output
// channel (out_valid/out_ready) carries controller command words, read
// bytes, done and error reports, and send-next-byte prompts; last marks
// the final result of one input transaction.
// Path: an accepted transaction waits in the input register until the
// queue has room, then the core decides it and its results are queued.
// Throughput: one input transaction per cycle while the output side keeps
// up; a transaction yields zero, one or two results, and the single output
// port drains one result per cycle while out_ready is high. A four-entry
// result queue decouples the sides.
// When the receiver stalls, the queue fills and in_ready drops once fewer
// than two slots are free; the input register then holds its transaction.
// Reset (rst, synchronous) returns the sequencer to idle with no transfer
// in progress and empties the result queue.
module i2c_register_transfer_sequencer import i2c_rts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [6:0] slave_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] byte_count,
  input  logic [7:0] tx_data,
  input  logic       ctrl_busy,
  input  logic       bus_busy,
  input  logic [2:0] error_bits,
  input  logic [7:0] rx_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] result_kind,
  output logic [7:0] addr_byte,
  output logic [7:0] data_byte,
  output logic [3:0] control_word,
  output logic [1:0] error_code,
  output logic       last
);

  item_t   item_q;
  logic    item_valid;
  logic    fire;
  logic    room;
  step_t   step;
  result_t head;

  assign fire     = item_valid && room;
  assign in_ready = !item_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.req        <= req_type;
      item_q.slave_addr <= slave_addr;
      item_q.reg_addr   <= reg_addr;
      item_q.byte_count <= byte_count;
      item_q.tx_data    <= tx_data;
      item_q.ctrl_busy  <= ctrl_busy;
      item_q.bus_busy   <= bus_busy;
      item_q.error_bits <= error_bits;
      item_q.rx_data    <= rx_data;
    end
  end

  // sequencing logic
  i2c_rts_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_q),
    .step (step)
  );

  // result queue
  i2c_rts_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (fire ? step.count : 2'd0),
    .wr0      (step.r0),
    .wr1      (step.r1),
    .room     (room),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign result_kind  = head.kind;
  assign addr_byte    = head.addr;
  assign data_byte    = head.data;
  assign control_word = head.ctrl;
  assign error_code   = head.err;
  assign last         = head.last;

  // a held transaction stays put until the queue takes it
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !fire |=> item_valid && $stable(item_q))
    else $error("input transaction lost while queue full");

  // a pair of results is always a read byte followed by its follow-up
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    fire && step.count == 2'd2 |-> step.r0.kind == KIND_RD)
    else $error("two results without a leading read byte");

  // only the final result of a transaction carries last
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    fire && step.count == 2'd2 |-> step.r1.last && !step.r0.last)
    else $error("last flag misplaced in result pair");

  // an accepted transaction is always registered
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> item_valid)
    else $error("accepted transaction not captured");

endmodule

// ----- dv/i2c_rts_transfer_checker.sv -----
// transfer predictor and result checker for the i2c register transfer sequencer
`timescale 1ns / 100ps

module i2c_rts_transfer_checker import i2c_rts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [6:0] slave_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] byte_count,
  input  logic [7:0] tx_data,
  input  logic       ctrl_busy,
  input  logic       bus_busy,
  input  logic [2:0] error_bits,
  input  logic [7:0] rx_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] result_kind,
  input  logic [7:0] addr_byte,
  input  logic [7:0] data_byte,
  input  logic [3:0] control_word,
  input  logic [1:0] error_code,
  input  logic       last,
  output int         mismatch_count,
  output int         outstanding
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W_ADDR,
    ST_W_NEED,
    ST_W_DATA,
    ST_R_ADDR,
    ST_R_DATA,
    ST_HOLD_OK,
    ST_HOLD_ERR
  } xfer_phase_e;

  // shadow of the sequencer state
  xfer_phase_e phase;
  logic        rd_mode;
  logic [6:0]  dev_addr;
  logic [7:0]  remaining;
  logic [7:0]  total;

  result_t expected_results[$];
  result_t txn_results[$];
  result_t exp_r;
  result_t got_r;

  function automatic void queue_result(logic [2:0] kind, logic [7:0] addr, logic [7:0] data,
                                       logic [3:0] ctrl, logic [1:0] err);
    result_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.ctrl = ctrl;
    r.err  = err;
    r.last = 1'b0;
    txn_results.push_back(r);
  endfunction

  // final report of a transfer, held back while the bus is busy
  function automatic void end_transfer(bit ok, bit bus_held);
    if (bus_held) begin
      phase = ok ? ST_HOLD_OK : ST_HOLD_ERR;
    end else begin
      phase = ST_IDLE;
      if (ok) begin
        queue_result(KIND_OK, 8'h00, 8'h00, 4'h0, ERR_NONE);
      end else begin
        queue_result(KIND_ERR, 8'h00, 8'h00, 4'h0, ERR_CTRL);
      end
    end
  endfunction

  // controller status report with ctrl_busy clear
  function automatic void apply_status(bit bus_held, bit fault, logic [7:0] rx);
    case (phase)
      ST_W_ADDR, ST_R_ADDR: begin
        if (fault) begin
          phase = ST_IDLE;
          queue_result(KIND_ERR, 8'h00, 8'h00, 4'h0, ERR_CTRL);
        end else if (phase == ST_W_ADDR) begin
          phase = ST_W_NEED;
          queue_result(KIND_NEXT, 8'h00, 8'h00, 4'h0, ERR_NONE);
        end else begin
          rd_mode = 1'b1;
          phase = ST_R_DATA;
          queue_result(KIND_CMD, {dev_addr, rd_mode}, 8'h00,
                       (total == 8'd1) ? CMD_START_RUN_STOP : CMD_START_RUN_ACK, ERR_NONE);
        end
      end
      ST_W_DATA: begin
        if (remaining == 8'd0) begin
          end_transfer(!fault, bus_held);
        end else if (fault) begin
          phase = ST_IDLE;
          queue_result(KIND_ERR, 8'h00, 8'h00, 4'h0, ERR_CTRL);
        end else begin
          phase = ST_W_NEED;
          queue_result(KIND_NEXT, 8'h00, 8'h00, 4'h0, ERR_NONE);
        end
      end
      ST_R_DATA: begin
        if (fault) begin
          // an error on the last byte is a final report, earlier ones abort at once
          if (remaining <= 8'd1) begin
            end_transfer(1'b0, bus_held);
          end else begin
            phase = ST_IDLE;
            queue_result(KIND_ERR, 8'h00, 8'h00, 4'h0, ERR_CTRL);
          end
        end else begin
          queue_result(KIND_RD, 8'h00, rx, 4'h0, ERR_NONE);
          if (remaining != 8'd0) remaining = remaining - 8'd1;
          if (remaining == 8'd0) begin
            end_transfer(1'b1, bus_held);
          end else begin
            queue_result(KIND_CMD, {dev_addr, rd_mode}, 8'h00,
                         (remaining == 8'd1) ? CMD_RUN_STOP : CMD_RUN_ACK, ERR_NONE);
          end
        end
      end
      ST_HOLD_OK, ST_HOLD_ERR: begin
        if (!bus_held) end_transfer(phase == ST_HOLD_OK, 1'b0);
      end
      default: ;
    endcase
  endfunction

  // expected results of one accepted input transaction
  function automatic void predict_transaction();
    txn_results.delete();
    if (req_type == REQ_BEGIN_WRITE || req_type == REQ_BEGIN_READ) begin
      if (phase != ST_IDLE) begin
        queue_result(KIND_ERR, 8'h00, 8'h00, 4'h0, ERR_ACTIVE);
      end else if (byte_count == 8'd0) begin
        queue_result(KIND_ERR, 8'h00, 8'h00, 4'h0, ERR_ZERO);
      end else begin
        dev_addr  = slave_addr;
        rd_mode   = 1'b0;
        total     = byte_count;
        remaining = byte_count;
        phase     = (req_type == REQ_BEGIN_WRITE) ? ST_W_ADDR : ST_R_ADDR;
        queue_result(KIND_CMD, {dev_addr, rd_mode}, reg_addr, CMD_START_RUN, ERR_NONE);
      end
    end else if (req_type == REQ_WRITE_BYTE) begin
      if (phase == ST_W_NEED && remaining != 8'd0) begin
        remaining = remaining - 8'd1;
        phase = ST_W_DATA;
        queue_result(KIND_CMD, {dev_addr, rd_mode}, tx_data,
                     (remaining == 8'd0) ? CMD_RUN_STOP : CMD_RUN, ERR_NONE);
      end
    end else if (!ctrl_busy) begin
      apply_status(bus_busy, error_bits != 3'd0, rx_data);
    end
    if (txn_results.size() > 0) txn_results[txn_results.size() - 1].last = 1'b1;
    foreach (txn_results[i]) expected_results.push_back(txn_results[i]);
  endfunction

  // compare accepted results, then predict from accepted inputs
  always @(posedge clk) begin
    if (rst) begin
      phase     = ST_IDLE;
      rd_mode   = 1'b0;
      dev_addr  = '0;
      remaining = '0;
      total     = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got_r.kind = result_kind;
        got_r.addr = addr_byte;
        got_r.data = data_byte;
        got_r.ctrl = control_word;
        got_r.err  = error_code;
        got_r.last = last;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: kind %0d addr %02h data %02h ctrl %h err %0d last %0b",
                     got_r.kind, got_r.addr, got_r.data, got_r.ctrl, got_r.err, got_r.last);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch: expected kind %0d addr %02h data %02h ctrl %h ",
                        "err %0d last %0b, got kind %0d addr %02h data %02h ctrl %h ",
                        "err %0d last %0b"},
                       exp_r.kind, exp_r.addr, exp_r.data, exp_r.ctrl, exp_r.err, exp_r.last,
                       got_r.kind, got_r.addr, got_r.data, got_r.ctrl, got_r.err, got_r.last);
          end
        end
      end
      if (in_valid && in_ready) predict_transaction();
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- dv/i2c_register_transfer_sequencer_tb.sv -----
// stimulus, clocking and verdict for the i2c register transfer sequencer
`timescale 1ns / 100ps

module i2c_register_transfer_sequencer_tb import i2c_rts_pkg::*;;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] req_type;
  logic [6:0] slave_addr;
  logic [7:0] reg_addr;
  logic [7:0] byte_count;
  logic [7:0] tx_data;
  logic       ctrl_busy;
  logic       bus_busy;
  logic [2:0] error_bits;
  logic [7:0] rx_data;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] result_kind;
  logic [7:0] addr_byte;
  logic [7:0] data_byte;
  logic [3:0] control_word;
  logic [1:0] error_code;
  logic       last;

  int mismatch_count;
  int outstanding;
  int items_sent;
  int random_start;
  int pick;
  int n;
  int fail_at;
  bit gaps_on;
  bit rx_hold_req;

  always #10 clk = ~clk;

  i2c_register_transfer_sequencer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .slave_addr(slave_addr), .reg_addr(reg_addr),
    .byte_count(byte_count), .tx_data(tx_data), .ctrl_busy(ctrl_busy),
    .bus_busy(bus_busy), .error_bits(error_bits), .rx_data(rx_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .addr_byte(addr_byte), .data_byte(data_byte),
    .control_word(control_word), .error_code(error_code), .last(last)
  );

  i2c_rts_transfer_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .slave_addr(slave_addr), .reg_addr(reg_addr),
    .byte_count(byte_count), .tx_data(tx_data), .ctrl_busy(ctrl_busy),
    .bus_busy(bus_busy), .error_bits(error_bits), .rx_data(rx_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .addr_byte(addr_byte), .data_byte(data_byte),
    .control_word(control_word), .error_code(error_code), .last(last),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  // offer one transaction and hold it until accepted
  task automatic send_item(input logic [1:0] req, input logic [6:0] sa, input logic [7:0] ra,
                           input logic [7:0] cnt, input logic [7:0] tx, input logic cb,
                           input logic bb, input logic [2:0] eb, input logic [7:0] rx);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    slave_addr <= sa;
    reg_addr   <= ra;
    byte_count <= cnt;
    tx_data    <= tx;
    ctrl_busy  <= cb;
    bus_busy   <= bb;
    error_bits <= eb;
    rx_data    <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic begin_req(input logic [1:0] req, input logic [6:0] sa, input logic [7:0] ra,
                           input logic [7:0] cnt);
    send_item(req, sa, ra, cnt, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic write_byte(input logic [7:0] tx);
    send_item(REQ_WRITE_BYTE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), tx, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic status_rep(input logic cb, input logic bb, input logic [2:0] eb,
                            input logic [7:0] rx);
    send_item(REQ_STATUS, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cb, bb, eb, rx);
  endtask

  // harmless while waiting on the controller: busy report or stray write byte
  task automatic busy_noise();
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      status_rep(1'b1, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)));
    end else if (pick == 1) begin
      write_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // begin request while a transfer runs
  task automatic active_noise();
    if ($urandom_range(0, 5) == 0)
      begin_req(2'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // let a held final report out once the bus goes idle
  task automatic release_hold(input logic held);
    if (held) begin
      repeat ($urandom_range(0, 2))
        status_rep(1'($urandom_range(0, 1)), 1'b1, 3'($urandom_range(0, 7)),
                   8'($urandom_range(0, 255)));
      status_rep(1'b0, 1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
  endtask

  // register burst write, aborted by a controller error at step fail_pt if within range
  task automatic run_write(input logic [6:0] sa, input logic [7:0] ra, input int cnt,
                           input int fail_pt);
    logic bb;
    begin_req(REQ_BEGIN_WRITE, sa, ra, 8'(cnt));
    busy_noise();
    if (fail_pt == 0) begin
      status_rep(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                 8'($urandom_range(0, 255)));
      return;
    end
    status_rep(1'b0, 1'($urandom_range(0, 1)), 3'd0, 8'($urandom_range(0, 255)));
    for (int i = 1; i <= cnt; i++) begin
      if ($urandom_range(0, 7) == 0)
        status_rep(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   8'($urandom_range(0, 255)));
      active_noise();
      write_byte(8'($urandom_range(0, 255)));
      busy_noise();
      bb = 1'($urandom_range(0, 1));
      if (i == fail_pt) begin
        status_rep(1'b0, bb, 3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
        if (i == cnt) release_hold(bb);
        return;
      end
      status_rep(1'b0, bb, 3'd0, 8'($urandom_range(0, 255)));
      if (i == cnt) release_hold(bb);
    end
  endtask

  // register burst read, same abort convention as the write
  task automatic run_read(input logic [6:0] sa, input logic [7:0] ra, input int cnt,
                          input int fail_pt);
    logic bb;
    begin_req(REQ_BEGIN_READ, sa, ra, 8'(cnt));
    busy_noise();
    if (fail_pt == 0) begin
      status_rep(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                 8'($urandom_range(0, 255)));
      return;
    end
    status_rep(1'b0, 1'($urandom_range(0, 1)), 3'd0, 8'($urandom_range(0, 255)));
    for (int i = 1; i <= cnt; i++) begin
      busy_noise();
      bb = 1'($urandom_range(0, 1));
      if (i == fail_pt) begin
        status_rep(1'b0, bb, 3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
        if (i == cnt) release_hold(bb);
        return;
      end
      status_rep(1'b0, bb, 3'd0, 8'($urandom_range(0, 255)));
      if (i == cnt) release_hold(bb);
      else active_noise();
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("i2c_register_transfer_sequencer test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    gaps_on     = 1'b1;
    rx_hold_req = 1'b0;
    items_sent  = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_STATUS;
    slave_addr <= '0;
    reg_addr   <= '0;
    byte_count <= '0;
    tx_data    <= '0;
    ctrl_busy  <= 1'b0;
    bus_busy   <= 1'b0;
    error_bits <= '0;
    rx_data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero count, stray status and stray write byte in idle
    begin_req(REQ_BEGIN_WRITE, 7'h00, 8'h00, 8'd0);
    begin_req(REQ_BEGIN_READ, 7'h7f, 8'hff, 8'd0);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    write_byte(8'h5a);

    // single byte write, begin while active, final report held on busy bus
    begin_req(REQ_BEGIN_WRITE, 7'h7f, 8'hff, 8'd1);
    status_rep(1'b1, 1'b0, 3'd7, 8'hff);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    begin_req(REQ_BEGIN_READ, 7'h00, 8'h00, 8'd5);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    write_byte(8'hff);
    status_rep(1'b0, 1'b1, 3'd0, 8'h00);
    status_rep(1'b0, 1'b1, 3'd0, 8'h00);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);

    // single byte read
    begin_req(REQ_BEGIN_READ, 7'h2a, 8'h55, 8'd1);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    status_rep(1'b0, 1'b0, 3'd0, 8'hff);

    // two byte read, error on the last byte while the bus is busy
    begin_req(REQ_BEGIN_READ, 7'h01, 8'h80, 8'd2);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    status_rep(1'b0, 1'b1, 3'b100, 8'h00);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);

    // full count aborted by address nack, then write aborted mid transfer
    begin_req(REQ_BEGIN_WRITE, 7'h40, 8'h01, 8'd255);
    status_rep(1'b0, 1'b0, 3'b010, 8'h00);
    begin_req(REQ_BEGIN_WRITE, 7'h15, 8'h3c, 8'd2);
    status_rep(1'b0, 1'b0, 3'd0, 8'h00);
    write_byte(8'h00);
    status_rep(1'b0, 1'b0, 3'b001, 8'h00);

    // sender waits for a full drain, then the receiver holds off while we push
    in_valid <= 1'b0;
    wait (outstanding == 0);
    rx_hold_req = 1'b1;
    repeat (8) begin_req(2'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255)), 8'd0);

    // random part: mostly well-formed transfers, some noise
    random_start = items_sent;
    while (items_sent - random_start < 130) begin
      if (items_sent - random_start >= 105) gaps_on = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) n = $urandom_range(1, 3);
        else if (pick < 9) n = $urandom_range(4, 8);
        else n = $urandom_range(9, 255);
        fail_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + 1;
        if (n > 8) fail_at = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0)
          run_write(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), n, fail_at);
        else
          run_read(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), n, fail_at);
      end else if (pick < 17) begin
        // arbitrary transactions, then force the block back to idle
        repeat ($urandom_range(1, 5))
          send_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)),
                    8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)));
        write_byte(8'($urandom_range(0, 255)));
        status_rep(1'b0, 1'b0, 3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 2);
        if (pick == 0)
          begin_req(2'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), 8'd0);
        else if (pick == 1)
          status_rep(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)));
        else
          write_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("i2c_register_transfer_sequencer test passed");
    end else begin
      $display("i2c_register_transfer_sequencer test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/i2c_rts_pkg.sv
hw/rtl/i2c_rts_core.sv
hw/rtl/i2c_rts_fifo.sv
hw/rtl/i2c_register_transfer_sequencer.sv
dv/i2c_rts_transfer_checker.sv
dv/i2c_register_transfer_sequencer_tb.sv
